// ===== rtl/core/chte_pkg.sv =====
// Shared constants, types and codes for the chained hash table engine.
`default_nettype none
package chte_pkg;

   localparam int unsigned POOL_SLOTS      = 1024;
   localparam int unsigned SLOT_W          = $clog2(POOL_SLOTS);
   localparam int unsigned LINK_W          = SLOT_W + 1;
   localparam int unsigned MAX_BUCKET_BITS = 10;
   localparam int unsigned BUCKETS         = 1 << MAX_BUCKET_BITS;
   localparam int unsigned BKT_W           = MAX_BUCKET_BITS;
   localparam int unsigned KEY_W           = 64;
   localparam int unsigned BITS_W          = 4;

   localparam logic [LINK_W-1:0] NO_SLOT   = LINK_W'(POOL_SLOTS);

   localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
   localparam int unsigned MUR_R    = 47;
   localparam logic [63:0] MUR_SEED = 64'h8445d61a4e774912;
   localparam logic [63:0] MUR_INIT = MUR_SEED ^ (MUR_M << 3);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [LINK_W-1:0] link;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/core/chained_hash_table_engine.sv =====
// Top level: request sequencer over the bucket-head and slot-entry memories.
//
//  Channel  Direction  Payload
//  req_*    in         tdata[63:0] key; tuser[1:0] operation
//  rsp_*    out        tdata[9:0] slot; tuser[0] found, tuser[2:1] status
//  csr_*    in         data[3:0] bucket_bits
//
// After reset all 1024 bucket heads are cleared, one per cycle.
// A lookup, a remove or an insert with a free slot is taken into the hash state, which
// starts the iterative hash, forms its four 64-bit products (each as three 32x32 partial
// products) and reads the bucket head. The head state follows, then chain entries are
// compared one per cycle, a slot is popped or freed where needed and the result register
// is loaded. A finished result waits in the output register while the next request is
// taken; the sequencer holds in its response state while it is occupied.
`default_nettype none
module chained_hash_table_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // key
   input  wire logic [7:0]  req_tuser,  // operation[1:0], zero above
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,  // slot[9:0], zero above
   output logic      [7:0]  rsp_tuser,  // found[0], status[2:1], zero above
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data    // bucket_bits
);
   import chte_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_HASH  = 8'b0000_0100,
      ST_HEAD  = 8'b0000_1000,
      ST_POP   = 8'b0001_0000,
      ST_WALK  = 8'b0010_0000,
      ST_FREE  = 8'b0100_0000,
      ST_RESP  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;
   logic [1:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [KEY_W-1:0]  prev_key_ff, prev_key_in;
   logic [SLOT_W-1:0] steps_ff, steps_in;
   logic              res_found_ff, res_found_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff, out_found_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [1:0]        out_status_ff, out_status_in;

   logic              hash_start, hash_done;
   logic [63:0]       hash_value;
   logic [BITS_W-1:0] bits_sat;
   logic [BKT_W-1:0]  bkt_mask;

   logic              hd_wr_en, hd_rd_en;
   logic [BKT_W-1:0]  hd_wr_addr, hd_rd_addr;
   logic [LINK_W-1:0] hd_wr_data, hd_rd_data;
   logic              en_wr_en, en_rd_en;
   logic [SLOT_W-1:0] en_wr_addr, en_rd_addr;
   entry_type         en_wr_data, en_rd_data;
   logic              out_free, req_fire;

   chte_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_ff),
      .done  (hash_done),
      .hash  (hash_value)
   );

   chte_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
      .clock   (clock),
      .wr_en   (hd_wr_en),
      .wr_addr (hd_wr_addr),
      .wr_data (hd_wr_data),
      .rd_en   (hd_rd_en),
      .rd_addr (hd_rd_addr),
      .rd_data (hd_rd_data)
   );

   chte_ram #(.WIDTH($bits(entry_type)), .DEPTH(POOL_SLOTS)) u_entries (
      .clock   (clock),
      .wr_en   (en_wr_en),
      .wr_addr (en_wr_addr),
      .wr_data (en_wr_data),
      .rd_en   (en_rd_en),
      .rd_addr (en_rd_addr),
      .rd_data (en_rd_data)
   );

   always_comb begin
      bits_sat = (bits_ff > BITS_W'(MAX_BUCKET_BITS)) ? BITS_W'(MAX_BUCKET_BITS) : bits_ff;
      for (int i = 0; i < BKT_W; i++) begin
         bkt_mask[i] = (BITS_W'(i) < bits_sat);
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      bits_in       = (csr_valid) ? csr_data : bits_ff;
      clr_in        = clr_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      bkt_in        = bkt_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_key_in   = prev_key_ff;
      steps_in      = steps_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_found_in  = out_found_ff;
      out_slot_in   = out_slot_ff;
      out_status_in = out_status_ff;
      hash_start    = 1'b0;
      hd_wr_en      = 1'b0;
      hd_wr_addr    = bkt_ff;
      hd_wr_data    = NO_SLOT;
      hd_rd_en      = 1'b0;
      hd_rd_addr    = hash_value[BKT_W-1:0] & bkt_mask;
      en_wr_en      = 1'b0;
      en_wr_addr    = cur_ff;
      en_wr_data    = '{key: key_ff, link: free_head_ff};
      en_rd_en      = 1'b0;
      en_rd_addr    = free_head_ff[SLOT_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            hd_wr_en   = 1'b1;
            hd_wr_addr = clr_ff;
            hd_wr_data = NO_SLOT;
            clr_in     = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_tuser[1:0];
               key_in        = req_tdata;
               res_found_in  = 1'b0;
               res_slot_in   = '0;
               res_status_in = STATUS_NOT_FOUND;
               if (req_tuser[1:0] == OP_INSERT) begin
                  if (free_head_ff[SLOT_W] && (fresh_ff == NO_SLOT)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_HASH;
                  end
               end else if ((req_tuser[1:0] == OP_LOOKUP) || (req_tuser[1:0] == OP_REMOVE)) begin
                  state_in = ST_HASH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_HASH: begin
            // The hash is started on the cycle after the key was captured.
            hash_start = !hash_done;
            if (hash_done) begin
               hd_rd_en = 1'b1;
               bkt_in   = hash_value[BKT_W-1:0] & bkt_mask;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            head_in = hd_rd_data;
            if (op_ff == OP_INSERT) begin
               if (!free_head_ff[SLOT_W]) begin
                  en_rd_en = 1'b1;
                  state_in = ST_POP;
               end else begin
                  en_wr_en      = 1'b1;
                  en_wr_addr    = fresh_ff[SLOT_W-1:0];
                  en_wr_data    = '{key: key_ff, link: hd_rd_data};
                  hd_wr_en      = 1'b1;
                  hd_wr_data    = fresh_ff;
                  fresh_in      = fresh_ff + LINK_W'(1);
                  res_found_in  = 1'b1;
                  res_slot_in   = fresh_ff[SLOT_W-1:0];
                  res_status_in = STATUS_OK;
                  state_in      = ST_RESP;
               end
            end else if (hd_rd_data[SLOT_W]) begin
               state_in = ST_RESP;
            end else begin
               en_rd_en   = 1'b1;
               en_rd_addr = hd_rd_data[SLOT_W-1:0];
               cur_in     = hd_rd_data[SLOT_W-1:0];
               prev_in    = NO_SLOT;
               steps_in   = '0;
               state_in   = ST_WALK;
            end
         end
         ST_POP: begin
            // The popped slot's link field holds the rest of the free list.
            free_head_in  = en_rd_data.link;
            en_wr_en      = 1'b1;
            en_wr_addr    = free_head_ff[SLOT_W-1:0];
            en_wr_data    = '{key: key_ff, link: head_ff};
            hd_wr_en      = 1'b1;
            hd_wr_data    = free_head_ff;
            res_found_in  = 1'b1;
            res_slot_in   = free_head_ff[SLOT_W-1:0];
            res_status_in = STATUS_OK;
            state_in      = ST_RESP;
         end
         ST_WALK: begin
            if (en_rd_data.key == key_ff) begin
               res_found_in  = 1'b1;
               res_slot_in   = cur_ff;
               res_status_in = STATUS_OK;
               if (op_ff == OP_REMOVE) begin
                  if (prev_ff[SLOT_W]) begin
                     hd_wr_en   = 1'b1;
                     hd_wr_data = en_rd_data.link;
                  end else begin
                     en_wr_en   = 1'b1;
                     en_wr_addr = prev_ff[SLOT_W-1:0];
                     en_wr_data = '{key: prev_key_ff, link: en_rd_data.link};
                  end
                  state_in = ST_FREE;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (en_rd_data.link[SLOT_W] || (steps_ff == SLOT_W'(POOL_SLOTS - 1))) begin
               state_in = ST_RESP;
            end else begin
               steps_in    = steps_ff + SLOT_W'(1);
               prev_in     = {1'b0, cur_ff};
               prev_key_in = en_rd_data.key;
               cur_in      = en_rd_data.link[SLOT_W-1:0];
               en_rd_en    = 1'b1;
               en_rd_addr  = en_rd_data.link[SLOT_W-1:0];
            end
         end
         ST_FREE: begin
            en_wr_en     = 1'b1;
            en_wr_addr   = cur_ff;
            en_wr_data   = '{key: key_ff, link: free_head_ff};
            free_head_in = {1'b0, cur_ff};
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_found_in  = res_found_ff;
               out_slot_in   = res_slot_ff;
               out_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bits_ff      <= BITS_W'(MAX_BUCKET_BITS);
         clr_ff       <= '0;
         free_head_ff <= NO_SLOT;
         fresh_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_ff      <= bits_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      bkt_ff        <= bkt_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_key_ff   <= prev_key_in;
      steps_ff      <= steps_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      out_found_ff  <= out_found_in;
      out_slot_ff   <= out_slot_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(16 - SLOT_W){1'b0}}, out_slot_ff};
   assign rsp_tuser  = {5'd0, out_status_ff, out_found_ff};

   // The fresh-slot counter never passes the pool size.
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NO_SLOT)
      else $error("fresh slot counter beyond pool");

   // A slot on the free list implies that slots have been handed out before.
   a_free_list: assert property (@(posedge clock) disable iff (reset)
      !free_head_ff[SLOT_W] |-> (fresh_ff != '0))
      else $error("free list holds a slot that was never allocated");

   // A result reports found exactly when its status is ok.
   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[2:1] == STATUS_OK)))
      else $error("found flag disagrees with status");

   // A removal that hits always pushes the slot back on the free list.
   a_remove_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE) |=> (free_head_ff == {1'b0, $past(cur_ff)}))
      else $error("removed slot not returned to the free list");

endmodule
`default_nettype wire

// ===== rtl/core/chte_ram.sv =====
// Generic single-port-write, single-port-read memory with a registered read.
`default_nettype none
module chte_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/chte_hash.sv =====
// Iterative MurmurHash64A of one 64-bit key, built on a shared 32x32 multiplier.
`default_nettype none
module chte_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] key,
   output logic             done,
   output logic      [63:0] hash
);
   import chte_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  round_ff, round_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] hash_ff, hash_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] fin, mix;

   // Each 64-bit product modulo 2^64 takes three partial products over four phases.
   always_comb begin
      mul_a   = (phase_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
      mul_b   = (phase_ff == 2'd1) ? MUR_M[63:32] : MUR_M[31:0];
      prod_in = 64'(mul_a) * 64'(mul_b);
      fin     = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
      mix     = fin ^ (fin >> MUR_R);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      round_in = round_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      hash_in  = hash_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in  = 1'b1;
            phase_in = 2'd0;
            round_in = 2'd0;
            x_in     = key;
         end
      end else begin
         phase_in = phase_ff + 2'd1;
         unique case (phase_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
            2'd3: begin
               round_in = round_ff + 2'd1;
               unique case (round_ff)
                  2'd0: x_in = mix;
                  2'd1: x_in = MUR_INIT ^ fin;
                  2'd2: x_in = mix;
                  2'd3: begin
                     hash_in = mix;
                     done_in = 1'b1;
                     busy_in = 1'b0;
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
         round_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         round_ff <= round_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      hash_ff <= hash_in;
   end

   assign done = done_ff;
   assign hash = hash_ff;

endmodule
`default_nettype wire
